// ----- hw/rtl/b64c_pkg.sv -----
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64c_pkg;

  localparam logic       DIR_ENCODE = 1'b0;
  localparam logic       DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] SYM_BAD    = 8'hFF;

  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RIDX_W    = $clog2(MAX_RES);

  // One input item's worth of results, handed from front to back.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [RIDX_W-1:0]       cnt_m1;  // number of results minus one
    logic                    valid;   // 0 only for a bare end marker
    logic                    last;    // final result carries out_last
  } cmd_t;

  // 6-bit value to alphabet character.
  function automatic logic [7:0] enc_sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)       c = 8'h41 + {2'b00, v};
    else if (v < 6'd52)  c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62)  c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

  // Alphabet character to 6-bit value; anything else gives SYM_BAD.
  function automatic logic [7:0] dec_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A)      v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == 8'h2B)               v = 8'd62;
    else if (c == 8'h2F)               v = 8'd63;
    else                               v = SYM_BAD;
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

endpackage

// ----- hw/rtl/b64c_front.sv -----
// Front end: accepts input beats, runs encoder/decoder state, builds result groups.
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              cmd_push,
  output b64c_pkg::cmd_t    cmd
);

  logic        direction;
  logic [1:0]  group_phase, group_phase_next;
  logic [3:0]  leftover_bits, leftover_bits_next;
  logic [15:0] accumulator, accumulator_next;
  logic [3:0]  bits_held, bits_held_next;
  logic        pad_seen, pad_seen_next;

  logic [1:0]  ph;
  logic [7:0]  sval;
  logic [4:0]  held;
  logic [4:0]  sh;
  logic [15:0] acc_new;
  logic [7:0]  dbyte;
  logic        demit;
  logic        blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= b64c_pkg::DIR_ENCODE;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  always_comb begin
    group_phase_next   = group_phase;
    leftover_bits_next = leftover_bits;
    accumulator_next   = accumulator;
    bits_held_next     = bits_held;
    pad_seen_next      = pad_seen;
    cmd                = '0;
    cmd_push           = 1'b0;
    ph      = (group_phase == 2'd3) ? 2'd0 : group_phase;
    blank   = b64c_pkg::is_blank(in_byte);
    sval    = b64c_pkg::dec_val(in_byte);
    acc_new = {accumulator[9:0], 6'd0} | {8'd0, sval};
    held    = {1'b0, bits_held} + 5'd6;
    sh      = (held >= 5'd8) ? held - 5'd8 : 5'd0;
    if (sh > 5'd8) sh = 5'd8;
    dbyte   = 8'(acc_new >> sh);
    demit   = 1'b0;

    if (direction == b64c_pkg::DIR_ENCODE) begin
      cmd.valid = 1'b1;
      case (ph)
        2'd0: begin
          cmd.chars[0] = b64c_pkg::enc_sym(in_byte[7:2]);
          if (in_last) begin
            cmd.chars[1] = b64c_pkg::enc_sym({in_byte[1:0], 4'd0});
            cmd.chars[2] = b64c_pkg::PAD_CHAR;
            cmd.chars[3] = b64c_pkg::PAD_CHAR;
            cmd.cnt_m1   = 2'd3;
          end
          leftover_bits_next = {2'd0, in_byte[1:0]};
          group_phase_next   = 2'd1;
        end
        2'd1: begin
          cmd.chars[0] = b64c_pkg::enc_sym({leftover_bits[1:0], in_byte[7:4]});
          if (in_last) begin
            cmd.chars[1] = b64c_pkg::enc_sym({in_byte[3:0], 2'd0});
            cmd.chars[2] = b64c_pkg::PAD_CHAR;
            cmd.cnt_m1   = 2'd2;
          end
          leftover_bits_next = in_byte[3:0];
          group_phase_next   = 2'd2;
        end
        default: begin
          cmd.chars[0] = b64c_pkg::enc_sym({leftover_bits, in_byte[7:6]});
          cmd.chars[1] = b64c_pkg::enc_sym(in_byte[5:0]);
          cmd.cnt_m1   = 2'd1;
          leftover_bits_next = 4'd0;
          group_phase_next   = 2'd0;
        end
      endcase
      cmd.last = in_last;
      cmd_push = accept;
    end else begin
      if (!blank && !pad_seen) begin
        if (in_byte == b64c_pkg::PAD_CHAR) begin
          pad_seen_next = 1'b1;
        end else begin
          demit            = (held >= 5'd8);
          accumulator_next = acc_new;
          bits_held_next   = demit ? 4'(held - 5'd8) : held[3:0];
        end
      end
      cmd.chars[0] = demit ? dbyte : 8'd0;
      cmd.valid    = demit;
      cmd.last     = in_last;
      cmd_push     = accept && (demit || in_last);
    end

    if (in_last) begin
      group_phase_next   = 2'd0;
      leftover_bits_next = 4'd0;
      accumulator_next   = 16'd0;
      bits_held_next     = 4'd0;
      pad_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= 2'd0;
      leftover_bits <= 4'd0;
      accumulator   <= 16'd0;
      bits_held     <= 4'd0;
      pad_seen      <= 1'b0;
    end else if (accept) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
      accumulator   <= accumulator_next;
      bits_held     <= bits_held_next;
      pad_seen      <= pad_seen_next;
    end
  end

endmodule

// ----- hw/rtl/b64c_queue.sv -----
// Short flop queue of result groups between front and back.
module b64c_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64c_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output b64c_pkg::cmd_t rdata,
  output logic           empty
);

  b64c_pkg::cmd_t                 slots [b64c_pkg::QDEPTH];
  logic [b64c_pkg::QPTR_W-1:0]    wptr, rptr;
  logic [b64c_pkg::QCNT_W-1:0]    count;
  logic                           do_push, do_pop;

  assign full    = (count == b64c_pkg::QCNT_W'(b64c_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rdata   = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == b64c_pkg::QPTR_W'(b64c_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == b64c_pkg::QPTR_W'(b64c_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/b64c_back.sv -----
// Back end: walks each result group and feeds the output register one beat at a time.
module b64c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  b64c_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_valid,
  output logic           out_last
);

  logic [b64c_pkg::RIDX_W-1:0] idx;
  logic                        held;
  logic                        load;
  logic                        at_end;

  assign empty  = !held;
  assign load   = (!held || pop) && !q_empty;
  assign at_end = (idx == q_head.cnt_m1);
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else begin
      if (load) begin
        held <= 1'b1;
        idx  <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= q_head.chars[idx];
      out_valid <= q_head.valid;
      out_last  <= q_head.last && at_end;
    end
  end

endmodule

// ----- hw/rtl/base64_stream_codec.sv -----
// Top level of the streaming base64 encoder/decoder.
// Streaming base64 codec (standard alphabet, '=' padding). cfg_data written with
// cfg_write selects encode (0) or decode (1). The new direction applies from the next
// accepted beat. Encoder and decoder keep their own message state across a switch.
// Input beats are taken one per cycle while the two-entry group queue has room;
// the output side delivers one beat per cycle from its output register while pop
// is high and results are waiting. Throughput is therefore set by the output port:
// an encoded byte yields one or two characters (up to four on the last byte of a
// message, with padding), averaging about 1.33 characters per input byte; a decoded
// character yields at most one byte. A last beat always produces a result flagged
// out_last, with out_valid low when no byte was produced. The first result of a
// beat passes through the group queue and then the output register to the ports.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  b64c_pkg::cmd_t cmd, q_head;
  logic           cmd_push;
  logic           q_empty, q_pop;
  logic           accept;

  assign accept = push && !full;

  b64c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  b64c_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd),
    .full (full),
    .pop  (q_pop),
    .rdata(q_head),
    .empty(q_empty)
  );

  b64c_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_valid(out_valid),
    .out_last (out_last)
  );

endmodule

// ----- dv/base64_stream_codec_tb.sv -----
// Self-checking testbench for the base64 stream codec: directed and random beats, both directions.
module base64_stream_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_MAX       = 17;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } b64_beat_t;

  typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD} grp_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  // Codec state as the predictor sees it
  logic        codec_dir = b64c_pkg::DIR_ENCODE;
  grp_phase_t  grp_phase = GRP_FIRST;
  logic [3:0]  grp_left = 4'h0;
  logic [15:0] dec_acc = 16'h0000;
  logic [3:0]  dec_bits = 4'h0;
  logic        dec_pad_seen = 1'b0;

  b64_beat_t expected_beats[$];
  int        errors = 0;
  int        sent_items = 0;
  int        tx_gap_cap = IDLE_MAX;
  int        rx_stall_cap = IDLE_MAX;
  logic      rx_hold_req = 1'b0;

  base64_stream_codec DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
  endfunction

  // Reverse lookup by scanning the alphabet; 8'hFF for anything outside it
  function automatic logic [7:0] symbol_value(input logic [7:0] c);
    int v;
    int i;
    v = 255;
    for (i = 0; i < 64; i++) begin
      if (b64_symbol(i[5:0]) == c) v = i;
    end
    return v[7:0];
  endfunction

  function automatic b64_beat_t data_beat(input logic [7:0] d);
    b64_beat_t r;
    r.data = d;
    r.valid = 1'b1;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic b64_beat_t char_beat(input logic [5:0] v);
    return data_beat(b64_symbol(v));
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = b64c_pkg::CH_TAB;
      1: c = b64c_pkg::CH_LF;
      2: c = b64c_pkg::CH_CR;
      default: c = b64c_pkg::CH_SPACE;
    endcase
    return c;
  endfunction

  // Works out the beats one accepted input causes and queues them
  function automatic void predict_codec(input logic [7:0] b, input logic last);
    b64_beat_t   res[$];
    b64_beat_t   tail;
    logic [15:0] acc;
    logic [15:0] shifted;
    int          held;
    logic        blank;
    blank = (b == b64c_pkg::CH_TAB) || (b == b64c_pkg::CH_LF) ||
            (b == b64c_pkg::CH_CR) || (b == b64c_pkg::CH_SPACE);
    if (codec_dir == b64c_pkg::DIR_ENCODE) begin
      case (grp_phase)
        GRP_FIRST: begin
          res = {res, char_beat(b[7:2])};
          grp_left = {2'b00, b[1:0]};
          grp_phase = GRP_SECOND;
        end
        GRP_SECOND: begin
          res = {res, char_beat({grp_left[1:0], b[7:4]})};
          grp_left = b[3:0];
          grp_phase = GRP_THIRD;
        end
        default: begin
          res = {res, char_beat({grp_left, b[7:6]})};
          res = {res, char_beat(b[5:0])};
          grp_left = 4'h0;
          grp_phase = GRP_FIRST;
        end
      endcase
      // short final group: flush the leftover bits, pad out to four chars
      if (last && grp_phase == GRP_SECOND) begin
        res = {res, char_beat({grp_left[1:0], 4'h0})};
        res = {res, data_beat(b64c_pkg::PAD_CHAR)};
        res = {res, data_beat(b64c_pkg::PAD_CHAR)};
      end else if (last && grp_phase == GRP_THIRD) begin
        res = {res, char_beat({grp_left, 2'b00})};
        res = {res, data_beat(b64c_pkg::PAD_CHAR)};
      end
    end else if (!blank && !dec_pad_seen) begin
      if (b == b64c_pkg::PAD_CHAR) begin
        dec_pad_seen = 1'b1;
      end else begin
        // bad chars OR all eight bits of 8'hFF in, not just six
        acc = (dec_acc << 6) | {8'h00, symbol_value(b)};
        held = int'(dec_bits) + 6;
        if (held >= 8) begin
          shifted = acc >> (held - 8);
          res = {res, data_beat(shifted[7:0])};
          held -= 8;
        end
        dec_acc = acc;
        dec_bits = 4'(held);
      end
    end
    if (last) begin
      if (res.size() == 0) begin
        tail = data_beat(8'h00);
        tail.valid = 1'b0;
        res = {res, tail};
      end
      tail = res.pop_back();
      tail.last = 1'b1;
      res = {res, tail};
      // end of message clears both directions
      grp_phase = GRP_FIRST;
      grp_left = 4'h0;
      dec_acc = 16'h0000;
      dec_bits = 4'h0;
      dec_pad_seen = 1'b0;
    end
    foreach (res[i]) expected_beats = {expected_beats, res[i]};
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_cap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_codec(b, last);
    sent_items++;
  endtask

  // Sender waits until every expected beat is back, then lets the pipe settle
  task automatic drain_and_settle();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    codec_dir = d;
  endtask

  task automatic pick_idle();
    tx_gap_cap = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    rx_stall_cap = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
  endtask

  task automatic send_byte_message();
    int len;
    int i;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
    for (i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Well-formed text with random content, blanks and padding; noise otherwise
  task automatic send_text_message();
    logic [7:0] text[$];
    int groups;
    int pads;
    int len;
    int i;
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 10);
      for (i = 0; i < len; i++) text = {text, 8'($urandom_range(0, 255))};
    end else begin
      groups = $urandom_range(1, 4);
      pads = $urandom_range(0, 2);
      for (i = 0; i < 4 * groups; i++) begin
        if ($urandom_range(0, 7) == 0) text = {text, blank_char()};
        if (i >= 4 * groups - pads) text = {text, b64c_pkg::PAD_CHAR};
        else text = {text, b64_symbol(6'($urandom_range(0, 63)))};
      end
      if ($urandom_range(0, 3) == 0) text = {text, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 5) == 0) text = {text, blank_char()};
    end
    for (i = 0; i < text.size(); i++) send_beat(text[i], i == text.size() - 1);
  endtask

  task automatic test_encode_tails();
    write_direction(b64c_pkg::DIR_ENCODE);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h4D, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h6E, 1'b1);
  endtask

  task automatic test_decode_filtering();
    drain_and_settle();
    write_direction(b64c_pkg::DIR_DECODE);
    send_beat("T", 1'b0);
    send_beat("W", 1'b0);
    send_beat(b64c_pkg::CH_SPACE, 1'b0);
    send_beat("F", 1'b0);
    send_beat(b64c_pkg::CH_TAB, 1'b0);
    send_beat("u", 1'b0);
    send_beat(b64c_pkg::CH_LF, 1'b0);
    send_beat(b64c_pkg::CH_CR, 1'b0);
    send_beat("!", 1'b0);
    send_beat(b64c_pkg::PAD_CHAR, 1'b0);
    send_beat("Q", 1'b1);
    // two bad chars in a row; the second one completes a byte
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // Flip direction between beats of unfinished messages
  task automatic test_direction_switch();
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    send_beat(8'h4D, 1'b0);
    drain_and_settle();
    write_direction(b64c_pkg::DIR_DECODE);
    send_beat("T", 1'b0);
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    send_beat(8'h61, 1'b0);
    drain_and_settle();
    write_direction(b64c_pkg::DIR_DECODE);
    send_beat("W", 1'b1);
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    send_beat(8'h6E, 1'b1);
  endtask

  task automatic test_random_encode(input int n);
    int stop;
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    stop = sent_items + n;
    while (sent_items < stop) begin
      pick_idle();
      send_byte_message();
    end
  endtask

  task automatic test_random_decode(input int n);
    int stop;
    drain_and_settle();
    write_direction(b64c_pkg::DIR_DECODE);
    stop = sent_items + n;
    while (sent_items < stop) begin
      pick_idle();
      send_text_message();
    end
  endtask

  task automatic test_backpressure();
    int stop;
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    tx_gap_cap = 0;
    rx_hold_req = 1'b1;
    stop = sent_items + 40;
    while (sent_items < stop) send_byte_message();
    drain_and_settle();
  endtask

  task automatic test_no_idle(input int n);
    int stop;
    tx_gap_cap = 0;
    rx_stall_cap = 0;
    drain_and_settle();
    write_direction(b64c_pkg::DIR_ENCODE);
    stop = sent_items + n;
    while (sent_items < stop) send_byte_message();
    drain_and_settle();
    write_direction(b64c_pkg::DIR_DECODE);
    stop = sent_items + n;
    while (sent_items < stop) send_text_message();
  endtask

  initial begin : result_checker
    b64_beat_t got;
    b64_beat_t want;
    int        stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_stall_cap);
      // long hold-off folds into the same idle stretch
      if (rx_hold_req) begin
        stall += RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.data = out_byte;
      got.valid = out_valid;
      got.last = out_last;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: byte %h valid %b last %b",
                 $time, got.data, got.valid, got.last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected byte %h valid %b last %b, got byte %h valid %b last %b",
                   $time, want.data, want.valid, want.last, got.data, got.valid, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_encode_tails();
    test_decode_filtering();
    test_direction_switch();
    test_random_encode(180);
    test_backpressure();
    test_random_decode(180);
    test_no_idle(30);
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
